FILE: design/hbs_pkg.sv
// Shared types and constants for the heightmap bilinear sampler.
// No dependencies; used by the interfaces and the top level.
package hbs_pkg;

   localparam int CELL_W = 8;
   localparam int CFG_W  = 9;

   localparam logic [CFG_W-1:0] GRID_WIDTH_RESET = 9'd64;

   localparam logic ACT_WRITE  = 1'b0;
   localparam logic ACT_SAMPLE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SAMPLE,
      ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      STEP_RD00,
      STEP_RD01,
      STEP_RD10,
      STEP_RD11,
      STEP_TOP,
      STEP_BOT,
      STEP_BOTQ,
      STEP_MULB,
      STEP_SUM
   } step_type;

endpackage

FILE: design/hbs_req_if.sv
// Request, response and register-write channels of the sampler.
// Depends on hbs_pkg for the cell index and register widths.
interface hbs_req_if #(
   parameter int HEIGHT_BITS     = 16,
   parameter int COORD_FRAC_BITS = 16
) ();
   logic                         valid;
   logic                         ready;
   logic                         action;
   logic [hbs_pkg::CELL_W-1:0]   cell_row;
   logic [hbs_pkg::CELL_W-1:0]   cell_col;
   logic signed [HEIGHT_BITS-1:0] height_in;
   logic [COORD_FRAC_BITS:0]     coord_x;
   logic [COORD_FRAC_BITS:0]     coord_z;

   modport source (output valid, action, cell_row, cell_col, height_in, coord_x, coord_z,
                   input ready);
   modport sink (input valid, action, cell_row, cell_col, height_in, coord_x, coord_z,
                 output ready);
endinterface

interface hbs_rsp_if #(
   parameter int HEIGHT_BITS = 16
) ();
   logic                          valid;
   logic                          ready;
   logic signed [HEIGHT_BITS-1:0] height_out;

   modport source (output valid, height_out, input ready);
   modport sink (input valid, height_out, output ready);
endinterface

interface hbs_csr_if ();
   logic                      valid;
   logic                      ready;
   logic [hbs_pkg::CFG_W-1:0] wdata;

   modport source (output valid, wdata, input ready);
   modport sink (input valid, wdata, output ready);
endinterface

FILE: design/hbs_axis.sv
// One sample axis: scales a coordinate by the grid width, clamps the cell
// pair into the grid and derives the two clamped blend weights. No dependencies.
module hbs_axis #(
   parameter int MAX_GRID        = 256,
   parameter int COORD_FRAC_BITS = 16,
   localparam int IDX_W          = $clog2(MAX_GRID),
   localparam int WW             = $clog2(MAX_GRID + 1)
) (
   input  logic [COORD_FRAC_BITS:0]   coord,
   input  logic [WW-1:0]              width,
   output logic [IDX_W-1:0]           idx0,
   output logic [IDX_W-1:0]           idx1,
   output logic [COORD_FRAC_BITS:0]   w_lo,
   output logic [COORD_FRAC_BITS:0]   w_hi
);
   localparam int F  = COORD_FRAC_BITS;
   localparam int SW = F + 1 + WW;
   localparam int FW = SW - F;
   localparam int DW = SW + 1;

   localparam logic signed [DW-1:0] ONE = DW'(1) << F;

   logic [SW-1:0]          scaled;
   logic [FW-1:0]          fl;
   logic [FW-1:0]          fl_p1;
   logic [FW-1:0]          wm1;
   logic [FW-1:0]          a;
   logic [FW-1:0]          b;
   logic signed [DW-1:0]   lo_diff;
   logic signed [DW-1:0]   hi_diff;

   function automatic logic [F:0] clamp_w(input logic signed [DW-1:0] d);
      logic [F:0] r;
      if (d < 0) begin
         r = '0;
      end else if (d > ONE) begin
         r = ONE[F:0];
      end else begin
         r = d[F:0];
      end
      return r;
   endfunction

   always_comb begin
      scaled  = SW'(coord) * SW'(width);
      fl      = scaled[SW-1:F];
      fl_p1   = fl + FW'(1);
      wm1     = FW'(width) - FW'(1);
      a       = (fl < wm1) ? fl : wm1;
      b       = (fl_p1 < wm1) ? fl_p1 : wm1;
      lo_diff = $signed({1'b0, b, {F{1'b0}}}) - $signed({1'b0, scaled});
      hi_diff = $signed({1'b0, scaled}) - $signed({1'b0, a, {F{1'b0}}});
      idx0    = a[IDX_W-1:0];
      idx1    = b[IDX_W-1:0];
      w_lo    = clamp_w(lo_diff);
      w_hi    = clamp_w(hi_diff);
   end

endmodule

FILE: design/heightmap_bilinear_sampler_top.sv
// Heightmap bilinear sampler: keeps a square grid of signed Q1.14 heights in one
// single-port synchronous memory and returns bilinearly blended samples.
// Depends on hbs_pkg, the channel interfaces in hbs_req_if.sv and hbs_axis.
//
// A write word returns nothing and leaves the block free for the next word. A
// sample word holds the block from acceptance until its result is loaded:
// the four corner reads go one per cycle through the single memory port, and
// the six blend products go through one shared multiplier with an accumulator.
// The result sits in an output register, so the next word is accepted while
// it waits. Grid contents are undefined until written; there is no clear pass.
// grid_width of 0 acts as 1 and above MAX_GRID acts as MAX_GRID.
module heightmap_bilinear_sampler_top #(
   parameter int MAX_GRID        = 256,
   parameter int HEIGHT_BITS     = 16,
   parameter int COORD_FRAC_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   hbs_req_if.sink    req_bus,
   hbs_rsp_if.source  rsp_bus,
   hbs_csr_if.sink    csr_bus
);
   import hbs_pkg::*;

   localparam int IDX_W  = $clog2(MAX_GRID);
   localparam int WW     = $clog2(MAX_GRID + 1);
   localparam int GW     = (WW > CFG_W) ? WW : CFG_W;
   localparam int EXT_W  = ((IDX_W > CELL_W) ? IDX_W : CELL_W) + 1;
   localparam int ADDR_W = 2 * IDX_W;
   localparam int HB     = HEIGHT_BITS;
   localparam int F      = COORD_FRAC_BITS;
   localparam int MA_W   = HB + 2;
   localparam int MB_W   = F + 2;
   localparam int P_W    = MA_W + MB_W;
   localparam int ACC_W  = P_W + 1;
   localparam int R_W    = ACC_W - F;

   localparam logic signed [R_W-1:0] HMAX = {{(R_W-HB+1){1'b0}}, {(HB-1){1'b1}}};
   localparam logic signed [R_W-1:0] HMIN = {{(R_W-HB+1){1'b1}}, {(HB-1){1'b0}}};
   localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (F - 1);

   // configuration
   logic [CFG_W-1:0] grid_width_ff;
   logic [GW-1:0]    gw_ext;
   logic [WW-1:0]    w_eff;

   // control
   state_type state_ff, state_in;
   step_type  step_ff, step_in;
   logic      req_fire;
   logic      sample_fire;
   logic      wr_en;
   logic      rsp_free;
   logic      rsp_load;

   // write addressing
   logic [EXT_W-1:0]  row_x;
   logic [EXT_W-1:0]  col_x;
   logic [ADDR_W-1:0] mem_addr;

   // axis results
   logic [IDX_W-1:0] ax_i0, ax_i1, az_i0, az_i1;
   logic [F:0]       ax_lo, ax_hi, az_lo, az_hi;
   logic [IDX_W-1:0] r0_ff, r1_ff, c0_ff, c1_ff;
   logic [F:0]       wx1_ff, wx0_ff, wz1_ff, wz0_ff;

   // memory and datapath
   logic [HB-1:0]             grid_mem [2**ADDR_W];
   logic [HB-1:0]             mem_q_ff;
   logic signed [MA_W-1:0]    mul_a;
   logic signed [MB_W-1:0]    mul_b;
   logic signed [P_W-1:0]     prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [MA_W-1:0]    hold_ff, hold_in;
   logic signed [ACC_W-1:0]   acc_half;
   logic signed [R_W-1:0]     rnd;
   logic signed [R_W-1:0]     sat;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [HB-1:0]      rsp_height_ff;

   // register port
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff <= GRID_WIDTH_RESET;
      end else if (csr_bus.valid) begin
         grid_width_ff <= csr_bus.wdata;
      end
   end

   always_comb begin
      gw_ext = GW'(grid_width_ff);
      if (gw_ext == '0) begin
         w_eff = WW'(1);
      end else if (gw_ext > GW'(MAX_GRID)) begin
         w_eff = WW'(MAX_GRID);
      end else begin
         w_eff = gw_ext[WW-1:0];
      end
   end

   // request side
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign sample_fire   = req_fire && (req_bus.action == ACT_SAMPLE);
   assign row_x         = EXT_W'(req_bus.cell_row);
   assign col_x         = EXT_W'(req_bus.cell_col);
   assign wr_en         = req_fire && (req_bus.action == ACT_WRITE)
                          && (row_x < EXT_W'(MAX_GRID)) && (col_x < EXT_W'(MAX_GRID));

   hbs_axis #(.MAX_GRID(MAX_GRID), .COORD_FRAC_BITS(F)) u_axis_x (
      .coord (req_bus.coord_x),
      .width (w_eff),
      .idx0  (ax_i0),
      .idx1  (ax_i1),
      .w_lo  (ax_lo),
      .w_hi  (ax_hi)
   );

   hbs_axis #(.MAX_GRID(MAX_GRID), .COORD_FRAC_BITS(F)) u_axis_z (
      .coord (req_bus.coord_z),
      .width (w_eff),
      .idx0  (az_i0),
      .idx1  (az_i1),
      .w_lo  (az_lo),
      .w_hi  (az_hi)
   );

   always_ff @(posedge clock) begin
      if (sample_fire) begin
         r0_ff  <= ax_i0;
         r1_ff  <= ax_i1;
         c0_ff  <= az_i0;
         c1_ff  <= az_i1;
         wx1_ff <= ax_lo;
         wx0_ff <= ax_hi;
         wz1_ff <= az_lo;
         wz0_ff <= az_hi;
      end
   end

   // grid memory, single port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         grid_mem[mem_addr] <= req_bus.height_in;
      end else begin
         mem_q_ff <= grid_mem[mem_addr];
      end
   end

   // rounding and saturation of the accumulator
   always_comb begin
      acc_half = acc_ff + HALF;
      rnd      = acc_half[ACC_W-1:F];
      if (rnd > HMAX) begin
         sat = HMAX;
      end else if (rnd < HMIN) begin
         sat = HMIN;
      end else begin
         sat = rnd;
      end
   end

   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;
   assign prod_in  = mul_a * mul_b;

   // sequencer: next state, memory address, multiplier operands, accumulator
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      mem_addr = {row_x[IDX_W-1:0], col_x[IDX_W-1:0]};
      mul_a    = MA_W'($signed(mem_q_ff));
      mul_b    = $signed({1'b0, wz1_ff});
      acc_in   = acc_ff;
      hold_in  = hold_ff;
      rsp_load = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (sample_fire) begin
               state_in = ST_SAMPLE;
               step_in  = STEP_RD00;
            end
         end
         ST_SAMPLE: begin
            unique case (step_ff)
               STEP_RD00: begin
                  mem_addr = {r0_ff, c0_ff};
                  step_in  = STEP_RD01;
               end
               STEP_RD01: begin
                  mem_addr = {r0_ff, c1_ff};
                  step_in  = STEP_RD10;
               end
               STEP_RD10: begin
                  mem_addr = {r1_ff, c0_ff};
                  mul_b    = $signed({1'b0, wz0_ff});
                  acc_in   = ACC_W'(prod_ff);
                  step_in  = STEP_RD11;
               end
               STEP_RD11: begin
                  mem_addr = {r1_ff, c1_ff};
                  acc_in   = acc_ff + ACC_W'(prod_ff);
                  step_in  = STEP_TOP;
               end
               STEP_TOP: begin
                  mem_addr = {r1_ff, c1_ff};
                  mul_b    = $signed({1'b0, wz0_ff});
                  hold_in  = rnd[MA_W-1:0];
                  acc_in   = ACC_W'(prod_ff);
                  step_in  = STEP_BOT;
               end
               STEP_BOT: begin
                  mem_addr = {r1_ff, c1_ff};
                  mul_a    = hold_ff;
                  mul_b    = $signed({1'b0, wx1_ff});
                  acc_in   = acc_ff + ACC_W'(prod_ff);
                  step_in  = STEP_BOTQ;
               end
               STEP_BOTQ: begin
                  mem_addr = {r1_ff, c1_ff};
                  mul_a    = hold_ff;
                  mul_b    = $signed({1'b0, wx1_ff});
                  hold_in  = rnd[MA_W-1:0];
                  acc_in   = ACC_W'(prod_ff);
                  step_in  = STEP_MULB;
               end
               STEP_MULB: begin
                  mem_addr = {r1_ff, c1_ff};
                  mul_a    = hold_ff;
                  mul_b    = $signed({1'b0, wx0_ff});
                  step_in  = STEP_SUM;
               end
               STEP_SUM: begin
                  mem_addr = {r1_ff, c1_ff};
                  acc_in   = acc_ff + ACC_W'(prod_ff);
                  state_in = ST_DONE;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_RD00;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      hold_ff <= hold_in;
      if (rsp_load) begin
         rsp_height_ff <= sat[HB-1:0];
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.height_out = rsp_height_ff;

endmodule

FILE: bench/tb_top.sv
// Testbench for heightmap_bilinear_sampler_top: drives write and sample words, predicts
// each blended height in a scoreboard class and checks every result word in order.
// Depends on hbs_pkg and the channel interfaces in hbs_req_if.sv.
module tb_top;
   import hbs_pkg::*;

   localparam int MAX_GRID   = 256;
   localparam int IDLE_LIMIT = 4000;
   localparam int SETTLE     = 16;

   typedef struct {
      logic                act;
      logic [CELL_W-1:0]   row;
      logic [CELL_W-1:0]   col;
      logic signed [15:0]  height;
      logic [16:0]         x;
      logic [16:0]         z;
   } req_word_type;

   class height_model;
      logic signed [15:0] heights [MAX_GRID*MAX_GRID];
      logic [CFG_W-1:0]   grid_width;
      logic signed [15:0] blend_q [$];
      int                 errors;
      int                 checked;

      function new();
         grid_width = GRID_WIDTH_RESET;
         errors     = 0;
         checked    = 0;
      endfunction

      static function int unsigned span_width(logic [CFG_W-1:0] gw);
         if (gw == '0) return 1;
         if (gw > CFG_W'(MAX_GRID)) return MAX_GRID;
         return 32'(gw);
      endfunction

      static function longint clamp_unit(longint v);
         if (v < 0) return 0;
         if (v > 65536) return 65536;
         return v;
      endfunction

      // cell index pair and the weights of the low and high index along one axis
      static function void split_axis(input logic [16:0] coord, input int unsigned gw,
                                      output int unsigned lo_idx, output int unsigned hi_idx,
                                      output longint lo_wt, output longint hi_wt);
         longint pos, whole, last, lo, hi;
         pos   = longint'(coord) * longint'(gw);
         whole = pos >>> 16;
         last  = longint'(gw) - 1;
         lo    = (whole < last) ? whole : last;
         hi    = (whole + 1 < last) ? whole + 1 : last;
         lo_wt  = clamp_unit((hi <<< 16) - pos);
         hi_wt  = clamp_unit(pos - (lo <<< 16));
         lo_idx = 32'(lo);
         hi_idx = 32'(hi);
      endfunction

      // nearest, ties toward +inf
      function longint round_q(longint v);
         return (v + 64'sd32768) >>> 16;
      endfunction

      function longint cell_at(int unsigned r, int unsigned c);
         return longint'(heights[r*MAX_GRID + c]);
      endfunction

      function void set_width(logic [CFG_W-1:0] v);
         grid_width = v;
      endfunction

      function void note_word(req_word_type w);
         int unsigned gw, r0, r1, c0, c1;
         longint wr_lo, wr_hi, wc_lo, wc_hi, upper, lower, mix;
         if (w.act == ACT_WRITE) begin
            heights[{w.row, w.col}] = w.height;
            return;
         end
         gw = span_width(grid_width);
         split_axis(w.x, gw, r0, r1, wr_lo, wr_hi);
         split_axis(w.z, gw, c0, c1, wc_lo, wc_hi);
         upper = round_q(cell_at(r0, c0) * wc_lo + cell_at(r0, c1) * wc_hi);
         lower = round_q(cell_at(r1, c0) * wc_lo + cell_at(r1, c1) * wc_hi);
         mix   = round_q(upper * wr_lo + lower * wr_hi);
         if (mix > 32767) mix = 32767;
         if (mix < -32768) mix = -32768;
         blend_q.insert(blend_q.size(), 16'(mix));
      endfunction

      function void check_word(logic signed [15:0] got);
         logic signed [15:0] want;
         if (blend_q.size() == 0) begin
            errors++;
            $display("%0t: height_out expected none, got %0d", $time, got);
            return;
         end
         want = blend_q.pop_front();
         checked++;
         if (got !== want) begin
            errors++;
            $display("%0t: height_out expected %0d, got %0d", $time, want, got);
         end
      endfunction

      function int pending();
         return blend_q.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   hbs_req_if #(.HEIGHT_BITS(16), .COORD_FRAC_BITS(16)) req_bus ();
   hbs_rsp_if #(.HEIGHT_BITS(16)) rsp_bus ();
   hbs_csr_if csr_bus ();

   heightmap_bilinear_sampler_top #(
      .MAX_GRID(MAX_GRID),
      .HEIGHT_BITS(16),
      .COORD_FRAC_BITS(16)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   height_model sb = new();

   bit          written [MAX_GRID*MAX_GRID];
   int unsigned cur_w = 32'(GRID_WIDTH_RESET);
   int          next_gap = 1;
   int          rsp_hold = 0;
   bit          calm = 1'b0;
   int          words_sent = 0;
   int          samples_sent = 0;
   int          idle_cycles = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) ||
          (csr_bus.valid === 1'b1 && csr_bus.ready === 1'b1))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: timeout, no word moved for %0d cycles", $time, IDLE_LIMIT);
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic int draw_gap();
      if (calm) return 0;
      if ($urandom_range(0, 2) == 0) return 0;
      return int'($urandom_range(1, 14));
   endfunction

   // result side: per-word stall, or a long hold when asked
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            sb.check_word(rsp_bus.height_out);
            stall_left = draw_gap();
         end
         if (rsp_hold > 0) begin
            stall_left = rsp_hold;
            rsp_hold   = 0;
         end
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task automatic send_word(input req_word_type w);
      repeat (next_gap) @(posedge clock);
      req_bus.valid     <= 1'b1;
      req_bus.action    <= w.act;
      req_bus.cell_row  <= w.row;
      req_bus.cell_col  <= w.col;
      req_bus.height_in <= w.height;
      req_bus.coord_x   <= w.x;
      req_bus.coord_z   <= w.z;
      @(posedge clock);
      while (!(req_bus.valid === 1'b1 && req_bus.ready === 1'b1)) @(posedge clock);
      sb.note_word(w);
      if (w.act == ACT_WRITE)
         written[{w.row, w.col}] = 1'b1;
      else
         samples_sent++;
      words_sent++;
      next_gap = draw_gap();
      if (next_gap > 0) req_bus.valid <= 1'b0;
   endtask

   // called right after an accepted word, so valid gets one assignment per step
   task automatic hold_sender();
      if (next_gap == 0) req_bus.valid <= 1'b0;
      next_gap = 1;
   endtask

   task automatic drain();
      hold_sender();
      while (sb.pending() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_grid_width(input logic [CFG_W-1:0] v);
      drain();
      csr_bus.valid <= 1'b1;
      csr_bus.wdata <= v;
      @(posedge clock);
      while (!(csr_bus.valid === 1'b1 && csr_bus.ready === 1'b1)) @(posedge clock);
      csr_bus.valid <= 1'b0;
      sb.set_width(v);
      cur_w = height_model::span_width(v);
   endtask

   function automatic logic signed [15:0] rand_height();
      case ($urandom_range(0, 7))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'sh0000;
         3: return -16'sd1;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic put(input int unsigned r, input int unsigned c,
                      input logic signed [15:0] h);
      req_word_type w;
      w.act    = ACT_WRITE;
      w.row    = 8'(r);
      w.col    = 8'(c);
      w.height = h;
      w.x      = 17'($urandom_range(0, 65536));
      w.z      = 17'($urandom_range(0, 65536));
      send_word(w);
   endtask

   task automatic fill_cell(input int unsigned r, input int unsigned c);
      if (!written[r*MAX_GRID + c]) put(r, c, rand_height());
   endtask

   // corners never written get a height first, so no read of an empty entry
   task automatic sample_at(input logic [16:0] x, input logic [16:0] z);
      int unsigned  r0, r1, c0, c1;
      longint       wa, wb, wc, wd;
      req_word_type w;
      height_model::split_axis(x, cur_w, r0, r1, wa, wb);
      height_model::split_axis(z, cur_w, c0, c1, wc, wd);
      fill_cell(r0, c0);
      fill_cell(r0, c1);
      fill_cell(r1, c0);
      fill_cell(r1, c1);
      w.act    = ACT_SAMPLE;
      w.row    = 8'($urandom);
      w.col    = 8'($urandom);
      w.height = 16'($urandom);
      w.x      = x;
      w.z      = z;
      send_word(w);
   endtask

   function automatic logic [16:0] coord_in_cell(int unsigned idx);
      int unsigned lo, hi;
      lo = (idx*65536 + cur_w - 1) / cur_w;
      hi = ((idx + 1)*65536 + cur_w - 1) / cur_w - 1;
      if (idx == cur_w - 1 && $urandom_range(0, 3) == 0) return 17'd65536;
      case ($urandom_range(0, 4))
         0: return 17'(lo);
         1: return 17'(hi);
         default: return 17'($urandom_range(lo, hi));
      endcase
   endfunction

   function automatic logic [16:0] edge_coord();
      case ($urandom_range(0, 4))
         0: return 17'd0;
         1: return 17'd65536;
         2: return 17'd65535;
         3: return 17'd1;
         default: return 17'($urandom_range(0, 65536));
      endcase
   endfunction

   task automatic cell_burst();
      int unsigned r, c, rn, cn, n;
      r  = $urandom_range(0, cur_w - 1);
      c  = $urandom_range(0, cur_w - 1);
      rn = (r + 1 < cur_w) ? r + 1 : r;
      cn = (c + 1 < cur_w) ? c + 1 : c;
      put(r, c, rand_height());
      put(r, cn, rand_height());
      put(rn, c, rand_height());
      put(rn, cn, rand_height());
      n = $urandom_range(1, 4);
      repeat (n) sample_at(coord_in_cell(r), coord_in_cell(c));
   endtask

   initial begin
      logic [CFG_W-1:0] width_plan [10];
      int               target;
      int               pick;
      int unsigned      r, c;

      width_plan = '{9'd64, 9'd1, 9'd256, 9'd0, 9'd2, 9'd511, 9'd7, 9'd255, 9'd0, 9'd64};
      width_plan[8] = 9'($urandom_range(3, 250));

      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.action    <= ACT_WRITE;
      req_bus.cell_row  <= '0;
      req_bus.cell_col  <= '0;
      req_bus.height_in <= '0;
      req_bus.coord_x   <= '0;
      req_bus.coord_z   <= '0;
      csr_bus.valid     <= 1'b0;
      csr_bus.wdata     <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: height extremes, half-way tie, far edge, store beyond the width
      put(0, 0, 16'sh7fff);
      put(0, 1, 16'sh8000);
      put(1, 0, 16'sh8000);
      put(1, 1, 16'sh7fff);
      sample_at(17'd0, 17'd0);
      sample_at(17'd512, 17'd512);
      sample_at(17'd0, 17'd512);
      sample_at(17'd1024, 17'd0);
      put(63, 63, 16'sh8000);
      sample_at(17'd65536, 17'd65536);
      sample_at(17'd65535, 17'd65535);
      sample_at(17'd65536, 17'd0);
      put(255, 255, 16'sd12345);
      put(200, 128, -16'sd1);

      for (int ph = 0; ph < 10; ph++) begin
         if (ph > 0) write_grid_width(width_plan[ph]);
         if (ph == 6) rsp_hold = 320;
         target = words_sent + 135;
         while (words_sent < target) begin
            if ($urandom_range(0, 19) == 0) calm = !calm;
            if ($urandom_range(0, 59) == 0) drain();
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
               cell_burst();
            end else if (pick < 65) begin
               sample_at(17'($urandom_range(0, 65536)), 17'($urandom_range(0, 65536)));
            end else if (pick < 75) begin
               sample_at(edge_coord(), edge_coord());
            end else if (pick < 90) begin
               put($urandom_range(0, 255), $urandom_range(0, 255), rand_height());
            end else begin
               r = $urandom_range(0, cur_w - 1);
               c = $urandom_range(0, cur_w - 1);
               put(r, c, rand_height());
               sample_at(coord_in_cell(r), coord_in_cell(c));
            end
         end
      end

      drain();
      repeat (20) @(posedge clock);
      $display("Sent %0d words, %0d of them samples, over 10 grid widths incl. 0 and 511;",
               words_sent, samples_sent);
      $display("checked %0d blended heights with random stalls and a long result hold.",
               sb.checked);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
